// ----- hw/rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

    // longest run of results one input beat can cause (a four byte utf-8 sequence)
    localparam int unsigned MaxRun   = 4;
    localparam int unsigned RunLenW  = $clog2(MaxRun + 1);
    localparam int unsigned RunIdxW  = $clog2(MaxRun);

    typedef enum logic [3:0] {
        ST_BYTE    = 4'd0,
        ST_DONE    = 4'd1,
        ST_NOQUOTE = 4'd2,
        ST_INCESC  = 4'd3,
        ST_BADESC  = 4'd4,
        ST_BADHEX  = 4'd5,
        ST_MISSLO  = 4'd6,
        ST_BADLO   = 4'd7,
        ST_UNTERM  = 4'd8,
        ST_SHORTU  = 4'd9
    } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_in_if.sv -----
`default_nettype none

interface jsu_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source
    (
        output valid,
        output in_byte,
        output end_of_input,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  in_byte,
        input  end_of_input,
        output ready
    );

endinterface

`default_nettype wire

// ----- hw/rtl/jsu_out_if.sv -----
`default_nettype none

interface jsu_out_if;

    logic              valid;
    logic              ready;
    logic [7:0]        out_byte;
    jsu_pkg::status_t  status;
    logic              last_of_run;

    modport source
    (
        output valid,
        output out_byte,
        output status,
        output last_of_run,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  out_byte,
        input  status,
        input  last_of_run,
        output ready
    );

endinterface

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8.sv -----
// an accepted beat reaches the output through the input register and then the run register
// throughput: one beat per cycle while each beat causes at most one result and the output is ready
// a beat with more than one result holds the run register, and so the input, until all are taken
// reset: rst_n is asynchronous, active low; parser returns to idle, both registers empty
`default_nettype none

module json_string_unescape_utf8
(
    input  wire        clk,
    input  wire        rst_n,
    jsu_in_if.sink     text,
    jsu_out_if.source  result
);

    localparam int unsigned LenW = jsu_pkg::RunLenW;
    localparam int unsigned IdxW = jsu_pkg::RunIdxW;

    // character codes
    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBsl   = 8'h5C;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLowB  = 8'h62;
    localparam logic [7:0] ChLowF  = 8'h66;
    localparam logic [7:0] ChLowN  = 8'h6E;
    localparam logic [7:0] ChLowR  = 8'h72;
    localparam logic [7:0] ChLowT  = 8'h74;
    localparam logic [7:0] ChLowU  = 8'h75;
    localparam logic [7:0] ChBs    = 8'h08;
    localparam logic [7:0] ChFf    = 8'h0C;
    localparam logic [7:0] ChLf    = 8'h0A;

    // surrogate ranges and utf-8 lead/continuation marks
    localparam logic [15:0] SurHiFirst = 16'hD800;
    localparam logic [15:0] SurHiLast  = 16'hDBFF;
    localparam logic [15:0] SurLoFirst = 16'hDC00;
    localparam logic [15:0] SurLoLast  = 16'hDFFF;
    localparam logic [20:0] SuppBase   = 21'h10000;
    localparam logic [20:0] Lim1       = 21'h80;
    localparam logic [20:0] Lim2       = 21'h800;
    localparam logic [7:0]  Lead2      = 8'hC0;
    localparam logic [7:0]  Lead3      = 8'hE0;
    localparam logic [7:0]  Lead4      = 8'hF0;
    localparam logic [7:0]  ContMark   = 8'h80;
    localparam logic [7:0]  ContMask   = 8'h3F;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_STR   = 7'b0000010,
        PH_ESC   = 7'b0000100,
        PH_HEX   = 7'b0001000,
        PH_BSL   = 7'b0010000,
        PH_LU    = 7'b0100000,
        PH_HEXLO = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [LenW-1:0]                 len;
        logic [jsu_pkg::MaxRun-1:0][7:0] bytes;
    } utf8_t;

    // hex digit to nibble, msb flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // code point to one..four utf-8 bytes
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp < Lim1)
        begin
            r.len      = LenW'(1);
            r.bytes[0] = cp[7:0];
        end
        else if (cp < Lim2)
        begin
            r.len      = LenW'(2);
            r.bytes[0] = Lead2 | {3'b000, cp[10:6]};
            r.bytes[1] = ContMark | ({2'b00, cp[5:0]} & ContMask);
        end
        else if (cp < SuppBase)
        begin
            r.len      = LenW'(3);
            r.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
            r.bytes[1] = ContMark | ({2'b00, cp[11:6]} & ContMask);
            r.bytes[2] = ContMark | ({2'b00, cp[5:0]} & ContMask);
        end
        else
        begin
            r.len      = LenW'(4);
            r.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
            r.bytes[1] = ContMark | ({2'b00, cp[17:12]} & ContMask);
            r.bytes[2] = ContMark | ({2'b00, cp[11:6]} & ContMask);
            r.bytes[3] = ContMark | ({2'b00, cp[5:0]} & ContMask);
        end
        return r;
    endfunction

    // input register
    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;

    // parser state
    phase_t      phase_reg, phase_next;
    logic [15:0] hex_value_reg, hex_value_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_half_reg, high_half_next;

    // run register: the results of one beat, drained one per cycle while the output is ready
    logic [LenW-1:0]                        run_len_reg;
    logic [IdxW-1:0]                        run_idx_reg;
    logic [jsu_pkg::MaxRun-1:0][7:0]        run_byte_reg;
    jsu_pkg::status_t [jsu_pkg::MaxRun-1:0] run_status_reg;

    // decode results
    logic [LenW-1:0]                        dec_len;
    logic [jsu_pkg::MaxRun-1:0][7:0]        dec_byte;
    jsu_pkg::status_t [jsu_pkg::MaxRun-1:0] dec_status;
    logic                                   err;
    jsu_pkg::status_t                       err_status;
    logic [4:0]                             hex_nib;
    logic [15:0]                            hex_shift;
    logic [20:0]                            cp;
    utf8_t                                  enc;
    logic                                   is_ws;

    logic pop;
    logic run_last;
    logic run_free;
    logic fire;

    // handshakes
    assign pop      = result.valid && result.ready;
    assign run_last = ({1'b0, run_idx_reg} == (run_len_reg - LenW'(1)));
    assign run_free = (run_len_reg == '0) || (pop && run_last);
    assign fire     = in_v_reg && run_free;

    assign text.ready = !in_v_reg || fire;

    assign result.valid       = (run_len_reg != '0);
    assign result.out_byte    = run_byte_reg[run_idx_reg];
    assign result.status      = run_status_reg[run_idx_reg];
    assign result.last_of_run = run_last;

    // shared pieces of the decode
    assign hex_nib   = hex_digit(in_byte_reg);
    assign hex_shift = {hex_value_reg[11:0], hex_nib[3:0]};
    // low half minus 0xDC00 is just its low ten bits
    assign cp        = (phase_reg == PH_HEXLO)
                       ? (SuppBase + {1'b0, high_half_reg, hex_shift[9:0]})
                       : {5'd0, hex_shift};
    assign enc       = utf8_encode(cp);
    assign is_ws     = (in_byte_reg == ChSpace) ||
                       (in_byte_reg >= ChTab && in_byte_reg <= ChCr);

    // one beat of the parser
    always_comb
    begin
        phase_next     = phase_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        high_half_next = high_half_reg;
        dec_len        = '0;
        dec_byte       = '0;
        dec_status     = {jsu_pkg::MaxRun{jsu_pkg::ST_BYTE}};
        err            = 1'b0;
        err_status     = jsu_pkg::ST_BYTE;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_eoi_reg)
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_NOQUOTE;
                end
                else if (is_ws)
                begin
                    phase_next = PH_IDLE;
                end
                else if (in_byte_reg == ChQuote)
                begin
                    phase_next = PH_STR;
                end
                else
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_NOQUOTE;
                end
            end
            PH_STR:
            begin
                if (in_eoi_reg)
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_UNTERM;
                end
                else if (in_byte_reg == ChQuote)
                begin
                    phase_next    = PH_IDLE;
                    dec_len       = LenW'(1);
                    dec_status[0] = jsu_pkg::ST_DONE;
                end
                else if (in_byte_reg == ChBsl)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    dec_len     = LenW'(1);
                    dec_byte[0] = in_byte_reg;
                end
            end
            PH_ESC:
            begin
                if (in_eoi_reg)
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_INCESC;
                end
                else if (in_byte_reg == ChLowU)
                begin
                    phase_next     = PH_HEX;
                    hex_count_next = '0;
                    hex_value_next = '0;
                end
                else
                begin
                    phase_next = PH_STR;
                    dec_len    = LenW'(1);
                    priority if (in_byte_reg == ChQuote || in_byte_reg == ChBsl ||
                                 in_byte_reg == ChSlash)
                        dec_byte[0] = in_byte_reg;
                    else if (in_byte_reg == ChLowB)
                        dec_byte[0] = ChBs;
                    else if (in_byte_reg == ChLowF)
                        dec_byte[0] = ChFf;
                    else if (in_byte_reg == ChLowN)
                        dec_byte[0] = ChLf;
                    else if (in_byte_reg == ChLowR)
                        dec_byte[0] = ChCr;
                    else if (in_byte_reg == ChLowT)
                        dec_byte[0] = ChTab;
                    else
                    begin
                        err        = 1'b1;
                        err_status = jsu_pkg::ST_BADESC;
                    end
                end
            end
            PH_HEX, PH_HEXLO:
            begin
                if (in_eoi_reg)
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_SHORTU;
                end
                else if (!hex_nib[4])
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_BADHEX;
                end
                else
                begin
                    hex_value_next = hex_shift;
                    if (hex_count_reg != 2'd3)
                    begin
                        hex_count_next = hex_count_reg + 2'd1;
                    end
                    else
                    begin
                        hex_count_next = '0;
                        if (phase_reg == PH_HEX)
                        begin
                            if (hex_shift >= SurHiFirst && hex_shift <= SurHiLast)
                            begin
                                // high surrogate: wait for the low half
                                high_half_next = hex_shift[9:0];
                                phase_next     = PH_BSL;
                            end
                            else
                            begin
                                phase_next = PH_STR;
                                dec_len    = enc.len;
                                dec_byte   = enc.bytes;
                            end
                        end
                        else if (hex_shift < SurLoFirst || hex_shift > SurLoLast)
                        begin
                            err        = 1'b1;
                            err_status = jsu_pkg::ST_BADLO;
                        end
                        else
                        begin
                            phase_next = PH_STR;
                            dec_len    = enc.len;
                            dec_byte   = enc.bytes;
                        end
                    end
                end
            end
            PH_BSL:
            begin
                if (in_eoi_reg || in_byte_reg != ChBsl)
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_MISSLO;
                end
                else
                begin
                    phase_next = PH_LU;
                end
            end
            PH_LU:
            begin
                if (in_eoi_reg || in_byte_reg != ChLowU)
                begin
                    err        = 1'b1;
                    err_status = jsu_pkg::ST_MISSLO;
                end
                else
                begin
                    phase_next     = PH_HEXLO;
                    hex_count_next = '0;
                    hex_value_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // every error gives one status result and drops back to idle
        if (err)
        begin
            phase_next     = PH_IDLE;
            hex_count_next = '0;
            hex_value_next = '0;
            dec_len        = LenW'(1);
            dec_byte       = '0;
            dec_status     = {jsu_pkg::MaxRun{jsu_pkg::ST_BYTE}};
            dec_status[0]  = err_status;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            hex_value_reg <= '0;
            hex_count_reg <= '0;
            high_half_reg <= '0;
            run_len_reg   <= '0;
            run_idx_reg   <= '0;
        end
        else
        begin
            if (text.valid && text.ready)
                in_v_reg <= 1'b1;
            else if (fire)
                in_v_reg <= 1'b0;

            if (fire)
            begin
                phase_reg     <= phase_next;
                hex_value_reg <= hex_value_next;
                hex_count_reg <= hex_count_next;
                high_half_reg <= high_half_next;
                run_len_reg   <= dec_len;
                run_idx_reg   <= '0;
            end
            else if (pop)
            begin
                if (run_last)
                begin
                    run_len_reg <= '0;
                    run_idx_reg <= '0;
                end
                else
                begin
                    run_idx_reg <= run_idx_reg + IdxW'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            in_byte_reg <= text.in_byte;
            in_eoi_reg  <= text.end_of_input;
        end
        if (fire)
        begin
            run_byte_reg   <= dec_byte;
            run_status_reg <= dec_status;
        end
    end

    // run pointer stays inside the run
    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_len_reg != '0 |-> {1'b0, run_idx_reg} < run_len_reg)
        else $error("run index beyond run length");

    // hex digit count only moves inside a hex group
    a_hex_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
        hex_count_reg != '0 |-> (phase_reg == PH_HEX || phase_reg == PH_HEXLO))
        else $error("hex count set outside a hex group");

    // done and error results always stand alone
    a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != jsu_pkg::ST_BYTE |-> result.last_of_run)
        else $error("status result not last of its run");

    // a decoded beat with results shows them next cycle
    a_run_shown: assert property (@(posedge clk) disable iff (!rst_n)
        fire && dec_len != '0 |=> result.valid)
        else $error("decoded run not presented");

    // an error returns the parser to idle with the hex digit count cleared
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        fire && err |=> phase_reg == PH_IDLE && hex_count_reg == '0)
        else $error("error did not return to idle");

endmodule

`default_nettype wire
